// File: hdl/nsf_pkg.sv
// Shared types and constants for the NMEA sentence framer.
package nsf_pkg;

   localparam int MAX_LINE_DEFAULT    = 90;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] CHAR_FILL   = 8'hFF;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam int MIN_CHECKED_LENGTH = 5;

   typedef enum logic [2:0] {
      KIND_GGA     = 3'd0,
      KIND_RMC     = 3'd1,
      KIND_GSV     = 3'd2,
      KIND_GLL     = 3'd3,
      KIND_GSA     = 3'd4,
      KIND_VTG     = 3'd5,
      KIND_UNKNOWN = 3'd6
   } kind_type;

   // One closed line, handed from the framing front to the checking back.
   typedef struct packed {
      logic [6:0]       line_length;
      logic             long_enough;
      logic [7:0]       running_xor;
      logic [2:0][7:0]  recent_bytes;  // [0] newest
      logic [2:0][7:0]  kind_bytes;    // line bytes 3, 4, 5
   } line_rec_type;

endpackage

// File: hdl/nmea_sentence_framer.sv
// Top level of the NMEA sentence framer: front, record queue and back.
// Throughput: one received byte per cycle; req_ready drops only while the record queue is full.
// The record enters the queue at the edge that accepts the line feed; the back loads it into
//   its result register, raising rsp_valid, once that register is empty or being taken.
// Reset (synchronous, active high): no line open, queue empty, no result pending.
// Bytes that close no line produce no result.
module nmea_sentence_framer #(
   parameter int MAX_LINE    = nsf_pkg::MAX_LINE_DEFAULT,
   parameter int QUEUE_DEPTH = nsf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_line_length,
   output logic       rsp_checksum_ok,
   output logic [7:0] rsp_computed_sum,
   output logic [2:0] rsp_sentence_kind
);

   logic                  byte_take;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_not_empty;
   nsf_pkg::line_rec_type q_in_rec;
   nsf_pkg::line_rec_type q_head_rec;

   // Hold off the sender only when no room is left for a closed line.
   assign req_ready = !q_full;
   assign byte_take = req_valid && req_ready;

   // Front: frame the byte stream, emit one record per line feed that closes an open line.
   nsf_front #(
      .MAX_LINE(MAX_LINE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .byte_take(byte_take),
      .rx_byte  (req_rx_byte),
      .rec_push (q_push),
      .rec_data (q_in_rec)
   );

   // Queue: decouple framing from result delivery.
   nsf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in_rec),
      .pop      (q_pop),
      .full     (q_full),
      .not_empty(q_not_empty),
      .head_data(q_head_rec)
   );

   // Back: check the checksum, classify, and hold the result until taken.
   nsf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rec_valid        (q_not_empty),
      .rec_data         (q_head_rec),
      .rec_pop          (q_pop),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_line_length  (rsp_line_length),
      .out_checksum_ok  (rsp_checksum_ok),
      .out_computed_sum (rsp_computed_sum),
      .out_sentence_kind(rsp_sentence_kind)
   );

   // A closed line must never meet a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("record pushed into a full queue");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A matching checksum needs the star and two digits, so the line is long enough.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_checksum_ok) |-> (MAX_LINE > 126 ||
                    rsp_line_length >= 7'(nsf_pkg::MIN_CHECKED_LENGTH)))
      else $error("checksum reported good on a short line");

endmodule

// File: hdl/nsf_front.sv
// Line framing front: tracks the open line and emits a record on each line feed that closes it.
module nsf_front #(
   parameter int MAX_LINE = nsf_pkg::MAX_LINE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_take,
   input  logic [7:0]           rx_byte,
   output logic                 rec_push,
   output nsf_pkg::line_rec_type rec_data
);

   localparam int FW = $clog2(MAX_LINE + 2);

   logic [FW-1:0]      fill_ff,   fill_in;
   logic [7:0]         xor_ff,    xor_in;
   logic [2:0][7:0]    recent_ff, recent_in;
   logic [2:0][7:0]    kind_ff,   kind_in;
   logic [FW+7:0]      len_wide;
   logic               keep_byte;
   logic               is_lf;

   assign is_lf     = (rx_byte == nsf_pkg::CHAR_LF);
   assign len_wide  = (FW+8)'(fill_ff) + (FW+8)'(1);
   assign keep_byte = byte_take && rx_byte != nsf_pkg::CHAR_FILL &&
                      rx_byte != nsf_pkg::CHAR_DOLLAR &&
                      fill_ff <= FW'(MAX_LINE) && fill_ff != '0 &&
                      rx_byte != nsf_pkg::CHAR_CR;

   always_comb begin
      fill_in   = fill_ff;
      xor_in    = xor_ff;
      recent_in = recent_ff;
      kind_in   = kind_ff;
      if (byte_take && rx_byte != nsf_pkg::CHAR_FILL) begin
         if (rx_byte == nsf_pkg::CHAR_DOLLAR) begin
            fill_in   = FW'(1);
            xor_in    = '0;
            recent_in = '0;
            kind_in   = '0;
         end else if (fill_ff > FW'(MAX_LINE)) begin
            // abandon an overlong line
            fill_in = '0;
         end else if (keep_byte) begin
            if (fill_ff == FW'(3)) kind_in[0] = rx_byte;
            if (fill_ff == FW'(4)) kind_in[1] = rx_byte;
            if (fill_ff == FW'(5)) kind_in[2] = rx_byte;
            if (is_lf) begin
               fill_in = '0;
            end else begin
               fill_in   = len_wide[FW-1:0];
               xor_in    = xor_ff ^ rx_byte;
               recent_in = {recent_ff[1], recent_ff[0], rx_byte};
            end
         end
      end
   end

   assign rec_push              = keep_byte && is_lf;
   assign rec_data.line_length  = len_wide[6:0];
   assign rec_data.long_enough  = (len_wide >= (FW+8)'(nsf_pkg::MIN_CHECKED_LENGTH));
   assign rec_data.running_xor  = xor_ff;
   assign rec_data.recent_bytes = recent_ff;
   assign rec_data.kind_bytes   = kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      xor_ff    <= xor_in;
      recent_ff <= recent_in;
      kind_ff   <= kind_in;
   end

endmodule

// File: hdl/nsf_queue.sv
// Short record queue between the framing front and the checking back.
module nsf_queue #(
   parameter int DEPTH = nsf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nsf_pkg::line_rec_type push_data,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output nsf_pkg::line_rec_type head_data
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   nsf_pkg::line_rec_type entry_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IW'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: hdl/nsf_back.sv
// Checking back: checksum compare, sentence classification and result register.
module nsf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rec_valid,
   input  nsf_pkg::line_rec_type rec_data,
   output logic                  rec_pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [6:0]            out_line_length,
   output logic                  out_checksum_ok,
   output logic [7:0]            out_computed_sum,
   output logic [2:0]            out_sentence_kind
);

   logic             valid_ff,  valid_in;
   logic [6:0]       length_ff;
   logic             ok_ff,     ok_in;
   logic [7:0]       sum_ff,    sum_in;
   nsf_pkg::kind_type kind_ff,  kind_in;
   logic             load;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? nsf_pkg::CHAR_ZERO + 8'(v)
                         : nsf_pkg::CHAR_UPPER_A + 8'(v) - 8'd10;
   endfunction

   function automatic logic kind_is(input logic [2:0][7:0] k,
                                    input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
      return k[0] == a && k[1] == b && k[2] == c;
   endfunction

   assign load    = rec_valid && (!valid_ff || out_ready);
   assign rec_pop = load;

   always_comb begin
      sum_in = '0;
      ok_in  = 1'b0;
      if (rec_data.long_enough) begin
         sum_in = rec_data.running_xor ^ rec_data.recent_bytes[0] ^
                  rec_data.recent_bytes[1] ^ rec_data.recent_bytes[2];
         ok_in  = rec_data.recent_bytes[2] == nsf_pkg::CHAR_STAR &&
                  rec_data.recent_bytes[1] == hex_digit(sum_in[7:4]) &&
                  rec_data.recent_bytes[0] == hex_digit(sum_in[3:0] &
                                                        nsf_pkg::NIBBLE_MASK);
      end
      if      (kind_is(rec_data.kind_bytes, "G", "G", "A")) kind_in = nsf_pkg::KIND_GGA;
      else if (kind_is(rec_data.kind_bytes, "R", "M", "C")) kind_in = nsf_pkg::KIND_RMC;
      else if (kind_is(rec_data.kind_bytes, "G", "S", "V")) kind_in = nsf_pkg::KIND_GSV;
      else if (kind_is(rec_data.kind_bytes, "G", "L", "L")) kind_in = nsf_pkg::KIND_GLL;
      else if (kind_is(rec_data.kind_bytes, "G", "S", "A")) kind_in = nsf_pkg::KIND_GSA;
      else if (kind_is(rec_data.kind_bytes, "V", "T", "G")) kind_in = nsf_pkg::KIND_VTG;
      else                                                   kind_in = nsf_pkg::KIND_UNKNOWN;
      if (load)           valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
      else                valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         length_ff <= rec_data.line_length;
         ok_ff     <= ok_in;
         sum_ff    <= sum_in;
         kind_ff   <= kind_in;
      end
   end

   assign out_valid         = valid_ff;
   assign out_line_length   = length_ff;
   assign out_checksum_ok   = ok_ff;
   assign out_computed_sum  = sum_ff;
   assign out_sentence_kind = 3'(kind_ff);

endmodule

// File: sim/tb_nmea_sentence_framer.sv
`timescale 1ns / 1ps
// Self-checking testbench for nmea_sentence_framer: directed and random byte streams.

module tb_nmea_sentence_framer;

   // The block runs with its default line limit; the line predictor uses the same limit.
   localparam int LINE_LIMIT   = nsf_pkg::MAX_LINE_DEFAULT;
   localparam int RANDOM_ITEMS = 1000;
   localparam int END_WAIT_MAX = 2000;

   // How the checksum tail of a generated sentence is built.
   typedef enum {SUM_GOOD, SUM_WRONG, SUM_LOWER, SUM_NO_STAR} sum_style_type;

   // One expected line result, one field per result port.
   typedef struct {
      logic [6:0]        line_length;
      logic              checksum_ok;
      logic [7:0]        computed_sum;
      nsf_pkg::kind_type sentence_kind;
   } line_result_type;

   // Line predictor and store of expected line results.
   class line_scoreboard;
      line_result_type expected_lines[$];
      int              mismatches;
      int              fill_count;
      logic [7:0]      running_xor;
      logic [7:0]      recent_bytes [3];
      logic [7:0]      kind_bytes [3];

      function new();
         mismatches = 0;
         fill_count = 0;
         clear_line();
      endfunction

      static function logic [7:0] hex_char(logic [3:0] v);
         return (v < 4'd10) ? nsf_pkg::CHAR_ZERO + {4'h0, v}
                            : nsf_pkg::CHAR_UPPER_A + {4'h0, v} - 8'd10;
      endfunction

      function void clear_line();
         running_xor = '0;
         for (int i = 0; i < 3; i++) begin
            recent_bytes[i] = '0;
            kind_bytes[i]   = '0;
         end
      endfunction

      function nsf_pkg::kind_type classify();
         logic [23:0] k;
         k = {kind_bytes[0], kind_bytes[1], kind_bytes[2]};
         case (k)
            "GGA":   return nsf_pkg::KIND_GGA;
            "RMC":   return nsf_pkg::KIND_RMC;
            "GSV":   return nsf_pkg::KIND_GSV;
            "GLL":   return nsf_pkg::KIND_GLL;
            "GSA":   return nsf_pkg::KIND_GSA;
            "VTG":   return nsf_pkg::KIND_VTG;
            default: return nsf_pkg::KIND_UNKNOWN;
         endcase
      endfunction

      // Advance the framing state by one accepted byte; queue a result on a closing LF.
      function void note_byte(logic [7:0] b);
         int              pos;
         line_result_type res;
         if (b == nsf_pkg::CHAR_FILL) return;
         if (b == nsf_pkg::CHAR_DOLLAR) begin
            fill_count = 1;
            clear_line();
            return;
         end
         // Over the limit: drop this byte and abandon the line.
         if (fill_count > LINE_LIMIT) begin
            fill_count = 0;
            return;
         end
         if (fill_count == 0 || b == nsf_pkg::CHAR_CR) return;
         pos        = fill_count;
         fill_count = pos + 1;
         if (pos >= 3 && pos <= 5) kind_bytes[pos - 3] = b;
         if (b == nsf_pkg::CHAR_LF) begin
            res.line_length  = 7'(fill_count);
            res.checksum_ok  = 1'b0;
            res.computed_sum = '0;
            if (fill_count >= nsf_pkg::MIN_CHECKED_LENGTH) begin
               res.computed_sum = running_xor ^ recent_bytes[0] ^ recent_bytes[1]
                                  ^ recent_bytes[2];
               res.checksum_ok  = (recent_bytes[2] == nsf_pkg::CHAR_STAR) &&
                                  (recent_bytes[1] == hex_char(res.computed_sum[7:4])) &&
                                  (recent_bytes[0] == hex_char(res.computed_sum[3:0]));
            end
            res.sentence_kind = classify();
            expected_lines.push_back(res);
            fill_count = 0;
            return;
         end
         running_xor ^= b;
         recent_bytes[2] = recent_bytes[1];
         recent_bytes[1] = recent_bytes[0];
         recent_bytes[0] = b;
      endfunction

      task report(string what, int got, int want);
         $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_line(logic [6:0] len, logic ok, logic [7:0] sum, logic [2:0] kind);
         line_result_type want;
         if (expected_lines.size() == 0) begin
            report("line with nothing expected, line_length", len, 0);
            return;
         end
         want = expected_lines.pop_front();
         if (len !== want.line_length) report("line_length", len, want.line_length);
         if (ok !== want.checksum_ok) report("checksum_ok", ok, want.checksum_ok);
         if (sum !== want.computed_sum) report("computed_sum", sum, want.computed_sum);
         if (kind !== want.sentence_kind) report("sentence_kind", kind, want.sentence_kind);
      endtask

      task close_out();
         if (expected_lines.size() != 0)
            report("lines never produced, count", 0, expected_lines.size());
      endtask
   endclass

   // Every block input starts at a known value; reset is held from time zero.
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_ready   = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [6:0] rsp_line_length;
   logic       rsp_checksum_ok;
   logic [7:0] rsp_computed_sum;
   logic [2:0] rsp_sentence_kind;

   line_scoreboard board = new();

   bit         idle_on    = 1'b1;  // random gaps and stalls on both sides
   bit         noise_on   = 1'b0;  // sprinkle fill and CR bytes into generated lines
   int         items_sent = 0;     // accepted bytes other than fill
   int         stall_left = 0;
   logic [7:0] line_q[$];          // bytes of the sequence being built
   logic [7:0] sentence_xor;       // XOR of the sequence body after the dollar
   string      kind_names [6] = '{"GGA", "RMC", "GSV", "GLL", "GSA", "VTG"};

   always #10 clock = ~clock;

   nmea_sentence_framer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_length   (rsp_line_length),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_sentence_kind (rsp_sentence_kind)
   );

   // Receiver side: stall in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every result transaction against the oldest expected line.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_line(rsp_line_length, rsp_checksum_ok, rsp_computed_sum,
                          rsp_sentence_kind);
   end

   // Send one byte transaction. Call at a falling edge; return at the next falling
   // edge after acceptance, with valid still high so back-to-back bytes need no gap.
   task send_byte(logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_byte(b);
      if (b != nsf_pkg::CHAR_FILL) items_sent++;
      @(negedge clock);
   endtask

   // Send the built sequence, optionally injecting fill and CR bytes, and clear it.
   task send_line_bytes();
      foreach (line_q[i]) begin
         if (noise_on && $urandom_range(0, 29) == 0) send_byte(nsf_pkg::CHAR_FILL);
         if (noise_on && $urandom_range(0, 39) == 0) send_byte(nsf_pkg::CHAR_CR);
         send_byte(line_q[i]);
      end
      line_q.delete();
   endtask

   task begin_sentence();
      line_q.push_back(nsf_pkg::CHAR_DOLLAR);
      sentence_xor = '0;
   endtask

   task push_body_byte(logic [7:0] b);
      line_q.push_back(b);
      sentence_xor ^= b;
   endtask

   task push_text(string s);
      for (int i = 0; i < s.len(); i++) push_body_byte(s[i]);
   endtask

   // Append the star, two hex digits, an optional CR and the closing LF.
   task close_sentence(sum_style_type style, bit with_cr);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      sum = sentence_xor;
      if (style == SUM_WRONG) sum ^= 8'($urandom_range(1, 255));
      hi = line_scoreboard::hex_char(sum[7:4]);
      lo = line_scoreboard::hex_char(sum[3:0]);
      if (style == SUM_LOWER) begin
         if (hi >= nsf_pkg::CHAR_UPPER_A) hi |= 8'h20;
         if (lo >= nsf_pkg::CHAR_UPPER_A) lo |= 8'h20;
      end
      // A dash takes the place of the star when the star is to be missing.
      line_q.push_back(style == SUM_NO_STAR ? 8'h2D : nsf_pkg::CHAR_STAR);
      line_q.push_back(hi);
      line_q.push_back(lo);
      if (with_cr) line_q.push_back(nsf_pkg::CHAR_CR);
      line_q.push_back(nsf_pkg::CHAR_LF);
   endtask

   // Printable byte for sentence bodies; never a dollar, which would restart the line.
   function logic [7:0] body_char();
      logic [7:0] b;
      b = 8'($urandom_range(8'h20, 8'h7E));
      return (b == nsf_pkg::CHAR_DOLLAR) ? 8'h2C : b;
   endfunction

   task directed_part();
      // Bytes with no line open, a stray LF and a fill byte: all ignored.
      push_text("xy\n");
      line_q.push_back(nsf_pkg::CHAR_FILL);
      send_line_bytes();
      // Every sentence kind plus an unknown one, all with good checksums.
      foreach (kind_names[k]) begin
         begin_sentence();
         push_text({"GP", kind_names[k], ",123519,4807.038,N"});
         close_sentence(SUM_GOOD, k % 2);
      end
      begin_sentence();
      push_text("GPXYZ,1");
      close_sentence(SUM_GOOD, 1'b1);
      // Wrong, lower-case and starless checksum tails: kind is still reported.
      begin_sentence();
      push_text("GPGGA,9");
      close_sentence(SUM_WRONG, 1'b0);
      begin_sentence();
      push_text("GPRMC,A,B,C,D,E,F,G");
      close_sentence(SUM_LOWER, 1'b1);
      begin_sentence();
      push_text("GPGSV,3");
      close_sentence(SUM_NO_STAR, 1'b0);
      // Short lines, from the bare dollar up to the first checked length.
      push_text("$\n$A\n$AB\n$ABC\n$GP\n");
      send_line_bytes();
      // CR and fill bytes inside a line are transparent.
      begin_sentence();
      push_text("GPGLL");
      line_q.push_back(nsf_pkg::CHAR_CR);
      line_q.push_back(nsf_pkg::CHAR_FILL);
      push_text(",1,2");
      close_sentence(SUM_GOOD, 1'b1);
      // Dollar inside a line restarts it.
      push_text("$GPGGA,12,");
      begin_sentence();
      push_text("GPRMC,A");
      close_sentence(SUM_GOOD, 1'b0);
      // Extreme body bytes.
      begin_sentence();
      push_text("GPGSA");
      push_body_byte(8'h00);
      push_body_byte(8'h80);
      push_body_byte(8'hFE);
      push_body_byte(8'h7F);
      close_sentence(SUM_GOOD, 1'b0);
      send_line_bytes();
      // Longest accepted line: 91 bytes with the LF.
      begin_sentence();
      push_text("GPVTG");
      for (int i = 0; i < LINE_LIMIT - 9; i++) push_body_byte(8'h41 + 8'(i % 26));
      close_sentence(SUM_GOOD, 1'b0);
      // One byte longer: the LF lands over the limit and is dropped.
      begin_sentence();
      push_text("GPVTG");
      for (int i = 0; i < LINE_LIMIT - 8; i++) push_body_byte(8'h61 + 8'(i % 26));
      close_sentence(SUM_GOOD, 1'b0);
      // Over the limit, then a dollar restarts cleanly.
      begin_sentence();
      for (int i = 0; i < LINE_LIMIT + 2; i++) push_body_byte(8'h30 + 8'(i % 10));
      begin_sentence();
      push_text("GNGGA,5");
      close_sentence(SUM_GOOD, 1'b1);
      // Over the limit, a fill is ignored, the next byte abandons, the LF finds no line.
      begin_sentence();
      for (int i = 0; i < LINE_LIMIT; i++) push_body_byte(8'h42);
      line_q.push_back(nsf_pkg::CHAR_FILL);
      line_q.push_back(8'h5A);
      line_q.push_back(nsf_pkg::CHAR_LF);
      send_line_bytes();
   endtask

   task random_part();
      int         start;
      int         pick;
      int         n;
      int         s;
      bit         full_range;
      logic [7:0] b;
      start    = items_sent;
      noise_on = 1'b1;
      while (items_sent - start < RANDOM_ITEMS) begin
         // Drop all idling for the last stretch of the run.
         idle_on = (items_sent - start) < (RANDOM_ITEMS * 85) / 100;
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            // Well-formed sentence with random content.
            begin_sentence();
            push_text(pick % 2 ? "GP" : "GN");
            n = $urandom_range(0, 7);
            if (n < 6) begin
               push_text(kind_names[n]);
            end else if (n == 6) begin
               repeat (3) push_body_byte(8'($urandom_range(8'h41, 8'h5A)));
            end
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(76, 84) : $urandom_range(0, 30);
            full_range = ($urandom_range(0, 9) == 0);
            repeat (n) begin
               b = full_range ? 8'($urandom_range(0, 255)) : body_char();
               push_body_byte(b == nsf_pkg::CHAR_DOLLAR ? 8'h2C : b);
            end
            s = $urandom_range(0, 19);
            close_sentence(s < 14 ? SUM_GOOD : s < 16 ? SUM_WRONG :
                           s < 18 ? SUM_LOWER : SUM_NO_STAR, $urandom_range(0, 1));
         end else if (pick < 84) begin
            // Short or broken line.
            begin_sentence();
            repeat ($urandom_range(0, 6)) push_body_byte(body_char());
            line_q.push_back(nsf_pkg::CHAR_LF);
         end else if (pick < 94) begin
            // Raw noise over the full byte range.
            repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
         end else begin
            // Line near or over the limit, then a LF and one more random byte.
            begin_sentence();
            repeat ($urandom_range(LINE_LIMIT - 2, LINE_LIMIT + 10))
               push_body_byte(body_char());
            line_q.push_back(nsf_pkg::CHAR_LF);
            line_q.push_back(8'($urandom_range(0, 255)));
         end
         send_line_bytes();
      end
   endtask

   initial begin
      int waited;
      // Hold reset, then release it at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_part();
      random_part();
      req_valid <= 1'b0;
      // Wait for every expected line, then keep waiting to catch extra results.
      waited = 0;
      while (board.expected_lines.size() > 0 && waited < END_WAIT_MAX) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      board.close_out();
      if (board.mismatches == 0) begin
         $display("nmea_sentence_framer regression: pass");
      end else begin
         $display("nmea_sentence_framer regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("nmea_sentence_framer regression: fail");
      $finish;
   end

endmodule
